// ----- hdl/gtpf_pkg.sv -----
// shared types, constants and font table for the glyph to page framebuffer
package gtpf_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_DEPTH    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int CELL_COLS      = 5;
    localparam int CELL_ROWS      = 7;
    localparam int DRAW_STEPS     = 2 * CELL_COLS;
    localparam int STEP_W         = $clog2(DRAW_STEPS);

    localparam logic [1:0] KIND_DRAW   = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [0:0] STATUS_DONE    = 1'b0;
    localparam logic [0:0] STATUS_CLIPPED = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [2:0] read_page;
        logic [6:0] read_column;
    } t_request;

    typedef struct packed {
        logic [0:0] status;
        logic [7:0] read_byte;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DRAW,
        S_READ,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic draw_step;
        logic read_issue;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_clip;
        logic sweep_last;
        logic draw_last;
    } t_dp_status;

    localparam logic [0:9][0:4][7:0] FONT_DIGITS = {
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E
    };

    localparam logic [0:25][0:4][7:0] FONT_CAPS = {
        8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
        8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
        8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,  8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
        8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,  8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
        8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,  8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
        8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,  8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
        8'h46, 8'h49, 8'h49, 8'h49, 8'h31,  8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
        8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,  8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
        8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,  8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
        8'h07, 8'h08, 8'h70, 8'h08, 8'h07,  8'h61, 8'h51, 8'h49, 8'h45, 8'h43
    };

    localparam logic [0:4][7:0] FONT_DASH    = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
    localparam logic [0:4][7:0] FONT_DOT     = {8'h00, 8'h00, 8'h00, 8'h60, 8'h60};
    localparam logic [0:4][7:0] FONT_COLON   = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
    localparam logic [0:4][7:0] FONT_PERCENT = {8'h63, 8'h13, 8'h08, 8'h64, 8'h63};

    localparam logic [7:0] CODE_DIGIT_0 = 8'h30;
    localparam logic [7:0] CODE_DIGIT_9 = 8'h39;
    localparam logic [7:0] CODE_CAP_A   = 8'h41;
    localparam logic [7:0] CODE_CAP_Z   = 8'h5A;
    localparam logic [7:0] CODE_DASH    = 8'h2D;
    localparam logic [7:0] CODE_DOT     = 8'h2E;
    localparam logic [7:0] CODE_COLON   = 8'h3A;
    localparam logic [7:0] CODE_PERCENT = 8'h25;

    // one glyph column, bit n is glyph row n; blank for codes without a glyph
    function automatic logic [7:0] font_column(logic [7:0] code, logic [2:0] col);
        logic [7:0] bits;
        logic [7:0] off;
        bits = 8'h00;
        off  = 8'h00;
        if (32'(col) < CELL_COLS) begin
            priority if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9) begin
                off  = code - CODE_DIGIT_0;
                bits = FONT_DIGITS[off[3:0]][col];
            end else if (code >= CODE_CAP_A && code <= CODE_CAP_Z) begin
                off  = code - CODE_CAP_A;
                bits = FONT_CAPS[off[4:0]][col];
            end else if (code == CODE_DASH) begin
                bits = FONT_DASH[col];
            end else if (code == CODE_DOT) begin
                bits = FONT_DOT[col];
            end else if (code == CODE_COLON) begin
                bits = FONT_COLON[col];
            end else if (code == CODE_PERCENT) begin
                bits = FONT_PERCENT[col];
            end else begin
                bits = 8'h00;
            end
        end
        return bits & 8'((1 << CELL_ROWS) - 1);
    endfunction

    // rows of a page that lie on the display
    function automatic logic [7:0] page_row_mask(logic [5:0] page);
        logic [7:0] mask;
        for (int n = 0; n < 8; n++) begin
            mask[n] = (32'(page) * 8 + n) < DISPLAY_HEIGHT;
        end
        return mask;
    endfunction

endpackage

// ----- hdl/gtpf_ctrl.sv -----
// request sequencer for the glyph to page framebuffer
module gtpf_ctrl
    import gtpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_kind,
    input  t_dp_status i_st,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_st.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_kind)
                        KIND_DRAW:   n_state = i_st.in_clip ? S_DONE : S_DRAW;
                        KIND_CLEAR:  n_state = S_CLEAR;
                        KIND_READ:   n_state = S_READ;
                        KIND_UNUSED: n_state = S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (i_st.sweep_last) n_state = S_DONE;
            end
            S_DRAW: begin
                if (i_st.draw_last) n_state = S_FLUSH;
            end
            S_READ:  n_state = S_FLUSH;
            S_FLUSH: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_start;
        o_cmd.clear_step = (r_state == S_INIT) || (r_state == S_CLEAR);
        o_cmd.draw_step  = (r_state == S_DRAW);
        o_cmd.read_issue = (r_state == S_READ);
        o_busy           = (r_state != S_IDLE);
        o_done           = (r_state == S_DONE);
    end

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_draw_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_kind == KIND_DRAW && !i_st.in_clip)
            |=> r_state == S_DRAW)
        else $error("unclipped draw request did not start drawing");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> o_done)
        else $error("flush not followed by result");

endmodule

// ----- hdl/gtpf_datapath.sv -----
// framebuffer memory, glyph column shifter and read-modify-write pipeline
module gtpf_datapath
    import gtpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_request   i_req,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_st,
    output t_result    o_result
);

    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [STEP_W-1:0] DRAW_LAST  = STEP_W'(DRAW_STEPS - 1);

    logic [7:0] r_mem [STORE_DEPTH];

    t_request          r_req;
    logic              r_clip;
    logic [ADDR_W-1:0] r_sweep;
    logic [STEP_W-1:0] r_step;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [7:0]        r_wr_bits;
    logic [7:0]        r_rdata;

    logic              in_clip;
    logic [2:0]        col;
    logic              half;
    logic [7:0]        glyph;
    logic [15:0]       shifted;
    logic [7:0]        draw_byte;
    logic [5:0]        draw_page;
    logic              draw_ok;
    logic [15:0]       draw_full;
    logic [ADDR_W-1:0] draw_addr;
    logic [15:0]       read_full;
    logic [ADDR_W-1:0] read_addr;
    logic              read_ok;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    assign in_clip = (i_req.kind == KIND_DRAW)
                  && ((9'(i_req.pos_x) + 9'(CELL_COLS)) >= 9'(DISPLAY_WIDTH));

    // even steps hit the top page of the cell, odd steps the page below
    assign col       = r_step[STEP_W-1:1];
    assign half      = r_step[0];
    assign glyph     = font_column(r_req.char_code, col);
    assign shifted   = 16'(glyph) << r_req.pos_y[2:0];
    assign draw_page = 6'(r_req.pos_y[7:3]) + 6'(half);
    assign draw_ok   = draw_page < 6'(PAGE_COUNT);
    assign draw_byte = (half ? shifted[15:8] : shifted[7:0]) & page_row_mask(draw_page);
    assign draw_full = 16'(draw_page) * 16'(DISPLAY_WIDTH) + 16'(r_req.pos_x) + 16'(col);
    assign draw_addr = draw_full[ADDR_W-1:0];

    assign read_ok   = (4'(r_req.read_page) < 4'(PAGE_COUNT))
                    && (8'(r_req.read_column) < 8'(DISPLAY_WIDTH));
    assign read_full = 16'(r_req.read_page) * 16'(DISPLAY_WIDTH) + 16'(r_req.read_column);
    assign read_addr = read_full[ADDR_W-1:0];

    assign rd_en   = (i_cmd.draw_step && draw_ok) || (i_cmd.read_issue && read_ok);
    assign rd_addr = i_cmd.draw_step ? draw_addr : read_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_addr;
        wr_data = r_rdata | r_wr_bits;
        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_sweep;
            wr_data = 8'h00;
        end else if (r_wr_pend) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= '0;
            r_step    <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_sweep <= (r_sweep == SWEEP_LAST) ? '0 : r_sweep + 1'b1;
            end
            if (i_cmd.load) begin
                r_step <= '0;
            end else if (i_cmd.draw_step) begin
                r_step <= (r_step == DRAW_LAST) ? '0 : r_step + 1'b1;
            end
            r_wr_pend <= i_cmd.draw_step && draw_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_clip <= in_clip;
        end
        if (i_cmd.draw_step) begin
            r_wr_addr <= draw_addr;
            r_wr_bits <= draw_byte;
        end
    end

    always_comb begin
        o_st            = '0;
        o_st.in_clip    = in_clip;
        o_st.sweep_last = i_cmd.clear_step && (r_sweep == SWEEP_LAST);
        o_st.draw_last  = i_cmd.draw_step && (r_step == DRAW_LAST);
        o_result.status = (r_req.kind == KIND_DRAW && r_clip) ? STATUS_CLIPPED
                                                               : STATUS_DONE;
        o_result.read_byte = (r_req.kind == KIND_READ && read_ok) ? r_rdata : 8'h00;
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= DRAW_LAST)
        else $error("draw step counter out of range");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_step && (i_cmd.draw_step || r_wr_pend || i_cmd.read_issue)))
        else $error("clear sweep overlaps a draw or read");

    a_pend_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> $past(i_cmd.draw_step))
        else $error("write-back without a preceding draw read");

endmodule

// ----- hdl/glyph_to_page_framebuffer.sv -----
// top level: 5x7 glyph renderer over a page-organised framebuffer
//
//  port      dir  kind               content
//  i_start   in   request strobe     taken when o_busy is low
//  i_req     in   t_request          kind, char_code, pos_x, pos_y, read_page, read_column
//  o_done    out  result strobe      one cycle per request, cannot be held off
//  o_result  out  t_result           status, read_byte
//
//  draw: ten steps in S_DRAW (up to ten read-modify-writes through the single
//  write port, one byte per cycle, none for a page off the display), then
//  S_FLUSH, S_DONE; clipped draw and unused kind: S_DONE; read: S_READ, S_FLUSH,
//  S_DONE; clear: S_CLEAR over all STORE_DEPTH bytes, S_DONE. after reset
//  all 1024 bytes go to zero, o_busy high; o_busy is high after accept through o_done.
module glyph_to_page_framebuffer
    import gtpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_request i_req,
    output logic     o_busy,
    output logic     o_done,
    output t_result  o_result
);

    t_ctrl_cmd  cmd;
    t_dp_status st;

    gtpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_req.kind),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    gtpf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_st     (st),
        .o_result (o_result)
    );

endmodule
